[rtl/cpf_pkg.sv]
// Package with item types, codes and sizes shared by the frame builder.
`default_nettype none
package cpf_pkg;
	localparam int FIFO_DEPTH = 512;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int BYTE_W = 8;
	localparam int FRAME_OVERHEAD = 6;
	localparam int WBUF_N = 6;
	localparam int WBUF_IDX_W = $clog2(WBUF_N);
	localparam int WBUF_CNT_W = $clog2(WBUF_N + 1);

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FOOTER = 1'b1;
	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;
	localparam logic [BYTE_W-1:0] FOOTER_RESET = 8'h55;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_PAYLOAD = 2'd1;
	localparam logic [1:0] OP_READY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_SEQERR = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic [15:0] frame_type;
		logic [7:0] frame_length;
		logic [7:0] payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic line_valid;
		logic [7:0] line_byte;
		logic sending;
	} out_item_t;
endpackage
`default_nettype wire

[rtl/checksummed_packet_framer.sv]
// Top level of the checksummed packet framer: control, write sequencer, output stage.
// A result passes through a read stage and an output register after its item is accepted.
// Throughput: a ready item every cycle while the output is not stalled; a payload or start item
// holds off new items until its bytes are written through the single RAM write port.
// Reset: pointers, counts, frame state and the output stage clear; header 0xAA, footer 0x55.
// FIFO contents are not cleared; no clearing pass is needed.
`default_nettype none
module checksummed_packet_framer (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [cpf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [cpf_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input logic in_valid,
	output logic in_ready,
	input cpf_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output cpf_pkg::out_item_t out_data
);
	import cpf_pkg::*;

	localparam logic [CNT_W:0] DEPTH_EXT = (CNT_W + 1)'(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	logic [BYTE_W-1:0] header_q, footer_q;
	logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [BYTE_W-1:0] sum_q, rem_q;
	logic frame_open_q, line_busy_q;

	logic [BYTE_W-1:0] wbuf_q [WBUF_N];
	logic [WBUF_CNT_W-1:0] wcnt_q;
	logic [WBUF_IDX_W-1:0] widx_q;

	logic s1_valid;
	logic [1:0] s1_status;
	logic s1_line_valid;
	logic s1_sending;
	logic out_valid_q;
	out_item_t out_q;

	logic [BYTE_W-1:0] rdata;
	logic acc, s1_move, room_ok, pop;
	logic [1:0] status_n;
	logic [WBUF_CNT_W-1:0] nwr;
	logic [BYTE_W-1:0] wb [WBUF_N];
	logic [BYTE_W-1:0] sum_hdr, sum_pay, rem_dec;
	logic [BYTE_W-1:0] sum_n, rem_n;
	logic open_n, busy_n;
	logic [PTR_W-1:0] rd_ptr_n;
	logic [CNT_W-1:0] fill_n;

	assign s1_move = s1_valid && (!out_valid_q || out_ready);
	assign in_ready = (wcnt_q == '0) && (!s1_valid || s1_move);
	assign acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign room_ok = ({1'b0, fill_q} + (CNT_W + 1)'(in_data.frame_length)
		+ (CNT_W + 1)'(FRAME_OVERHEAD)) <= DEPTH_EXT;
	assign sum_hdr = header_q + in_data.frame_length + in_data.frame_type[15:8]
		+ in_data.frame_type[7:0];
	assign sum_pay = sum_q + in_data.payload_byte;
	assign rem_dec = rem_q - 8'd1;

	always_comb begin
		status_n = ST_OK;
		pop = 1'b0;
		nwr = '0;
		for (int i = 0; i < WBUF_N; i++) begin
			wb[i] = '0;
		end
		sum_n = sum_q;
		rem_n = rem_q;
		open_n = frame_open_q;
		busy_n = line_busy_q;
		rd_ptr_n = rd_ptr_q;
		case (in_data.op)
			OP_START: begin
				if (frame_open_q) begin
					status_n = ST_SEQERR;
				end else if (!room_ok) begin
					status_n = ST_NOSPACE;
				end else begin
					wb[0] = header_q;
					wb[1] = in_data.frame_length;
					wb[2] = in_data.frame_type[15:8];
					wb[3] = in_data.frame_type[7:0];
					busy_n = 1'b1;
					if (in_data.frame_length == '0) begin
						wb[4] = sum_hdr;
						wb[5] = footer_q;
						nwr = WBUF_CNT_W'(6);
						sum_n = '0;
						rem_n = '0;
						open_n = 1'b0;
					end else begin
						nwr = WBUF_CNT_W'(4);
						sum_n = sum_hdr;
						rem_n = in_data.frame_length;
						open_n = 1'b1;
					end
				end
			end
			OP_PAYLOAD: begin
				if (!frame_open_q) begin
					status_n = ST_SEQERR;
				end else begin
					wb[0] = in_data.payload_byte;
					busy_n = 1'b1;
					rem_n = rem_dec;
					if (rem_dec == '0) begin
						wb[1] = sum_pay;
						wb[2] = footer_q;
						nwr = WBUF_CNT_W'(3);
						sum_n = '0;
						open_n = 1'b0;
					end else begin
						nwr = WBUF_CNT_W'(1);
						sum_n = sum_pay;
					end
				end
			end
			OP_READY: begin
				if (fill_q == '0) begin
					busy_n = 1'b0;
				end else begin
					pop = 1'b1;
					rd_ptr_n = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
				end
			end
			default: ;
		endcase
		fill_n = fill_q + CNT_W'(nwr) - CNT_W'(pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			footer_q <= FOOTER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER: header_q <= cfg_wdata;
				REG_FOOTER: footer_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			fill_q <= '0;
			sum_q <= '0;
			rem_q <= '0;
			frame_open_q <= 1'b0;
			line_busy_q <= 1'b0;
			wcnt_q <= '0;
			widx_q <= '0;
			s1_valid <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				rd_ptr_q <= rd_ptr_n;
				fill_q <= fill_n;
				sum_q <= sum_n;
				rem_q <= rem_n;
				frame_open_q <= open_n;
				line_busy_q <= busy_n;
				wcnt_q <= nwr;
				widx_q <= '0;
			end else if (wcnt_q != '0) begin
				wcnt_q <= wcnt_q - 1'b1;
				widx_q <= widx_q + 1'b1;
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (acc) begin
				s1_valid <= 1'b1;
			end else if (s1_move) begin
				s1_valid <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < WBUF_N; i++) begin
				wbuf_q[i] <= wb[i];
			end
			s1_status <= status_n;
			s1_line_valid <= pop;
			s1_sending <= busy_n;
		end
		if (s1_move) begin
			out_q.status <= s1_status;
			out_q.line_valid <= s1_line_valid;
			out_q.line_byte <= s1_line_valid ? rdata : '0;
			out_q.sending <= s1_sending;
		end
	end

	cpf_ram #(
		.DEPTH(FIFO_DEPTH),
		.WIDTH(BYTE_W)
	) u_ram (
		.clk(clk),
		.we(wcnt_q != '0),
		.waddr(wr_ptr_q),
		.wdata(wbuf_q[widx_q]),
		.re(acc && pop),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(fill_q) <= DEPTH_EXT)
		else $error("fill count above FIFO depth");
	a_write_drain: assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q != '0 |=> wcnt_q == $past(wcnt_q) - 1'b1)
		else $error("write sequencer did not advance");
	a_open_remaining: assert property (@(posedge clk) disable iff (!arst_n)
		frame_open_q |-> rem_q != '0)
		else $error("open frame with no bytes remaining");
`endif
endmodule
`default_nettype wire

[rtl/cpf_ram.sv]
// Simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module cpf_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking bench for the checksummed packet framer: directed and random items.
`timescale 1ns / 100ps

module tb;
	import cpf_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	checksummed_packet_framer dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	// framer shadow state
	logic [7:0] tx_ram [FIFO_DEPTH];
	int tx_rd = 0;
	int tx_wr = 0;
	int tx_fill = 0;
	logic [7:0] sum_acc = '0;
	logic [7:0] pay_left = '0;
	bit in_frame = 1'b0;
	bit busy_flag = 1'b0;
	logic [7:0] hdr_reg = HEADER_RESET;
	logic [7:0] ftr_reg = FOOTER_RESET;

	in_item_t pending_items[$];
	out_item_t expected_results[$];
	int mismatch_count = 0;
	int result_count = 0;
	int send_gap = 0;
	int recv_gap = 0;
	bit drv_burst = 1'b0;
	bit mon_burst = 1'b0;
	logic hold_arm = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_byte(input logic [7:0] b);
		busy_flag = 1'b1;
		if (tx_fill < FIFO_DEPTH) begin
			tx_ram[PTR_W'(tx_wr)] = b;
			tx_wr = (tx_wr + 1) % FIFO_DEPTH;
			tx_fill++;
		end
	endfunction

	function automatic void push_summed(input logic [7:0] b);
		push_byte(b);
		sum_acc = sum_acc + b;
	endfunction

	function automatic void close_frame();
		push_byte(sum_acc);
		push_byte(ftr_reg);
		in_frame = 1'b0;
		pay_left = '0;
		sum_acc = '0;
	endfunction

	function automatic void predict_item(input in_item_t it);
		out_item_t r;
		r = '0;
		case (it.op)
			OP_START: begin
				if (in_frame) begin
					r.status = ST_SEQERR;
				end else if (FIFO_DEPTH - tx_fill < int'(it.frame_length) + FRAME_OVERHEAD) begin
					r.status = ST_NOSPACE;
				end else begin
					sum_acc = '0;
					push_summed(hdr_reg);
					push_summed(it.frame_length);
					push_summed(it.frame_type[15:8]);
					push_summed(it.frame_type[7:0]);
					if (it.frame_length == 8'd0) begin
						close_frame();
					end else begin
						in_frame = 1'b1;
						pay_left = it.frame_length;
					end
				end
			end
			OP_PAYLOAD: begin
				if (!in_frame) begin
					r.status = ST_SEQERR;
				end else begin
					push_summed(it.payload_byte);
					pay_left = pay_left - 8'd1;
					if (pay_left == 8'd0)
						close_frame();
				end
			end
			OP_READY: begin
				if (tx_fill == 0) begin
					busy_flag = 1'b0;
				end else begin
					r.line_valid = 1'b1;
					r.line_byte = tx_ram[PTR_W'(tx_rd)];
					tx_rd = (tx_rd + 1) % FIFO_DEPTH;
					tx_fill--;
				end
			end
			default: begin
			end
		endcase
		r.sending = busy_flag;
		expected_results.push_back(r);
	endfunction

	function automatic int draw_wait(input bit burst);
		return burst ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic in_item_t rand_item(input logic [1:0] op);
		in_item_t it;
		it.op = op;
		it.frame_type = 16'($urandom_range(0, 65535));
		it.frame_length = 8'($urandom_range(0, 255));
		it.payload_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic add_start(input logic [7:0] len, input logic [15:0] ftype);
		in_item_t it;
		it = rand_item(OP_START);
		it.frame_length = len;
		it.frame_type = ftype;
		pending_items.push_back(it);
	endtask

	task automatic add_payload(input logic [7:0] b);
		in_item_t it;
		it = rand_item(OP_PAYLOAD);
		it.payload_byte = b;
		pending_items.push_back(it);
	endtask

	task automatic add_readies(input int n);
		repeat (n) pending_items.push_back(rand_item(OP_READY));
	endtask

	task automatic add_frame(input int len);
		add_start(8'(len), 16'($urandom_range(0, 65535)));
		repeat (len) add_payload(8'($urandom_range(0, 255)));
	endtask

	task automatic queue_random_traffic(input int n);
		int added;
		int pick;
		int len;
		int sent;
		int k;
		added = 0;
		while (added < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				k = $urandom_range(0, 9);
				if (k < 6)
					len = $urandom_range(0, 7);
				else if (k < 9)
					len = $urandom_range(8, 40);
				else
					len = $urandom_range(41, 255);
				// cut some frames short
				sent = (pick < 76) ? len : $urandom_range(0, len);
				add_start(8'(len), 16'($urandom_range(0, 65535)));
				k = $urandom_range(0, 8);
				add_readies(k);
				added += 1 + k;
				repeat (sent) begin
					add_payload(8'($urandom_range(0, 255)));
					k = $urandom_range(0, 2);
					add_readies(k);
					added += 1 + k;
				end
			end else if (pick < 85) begin
				add_payload(8'($urandom_range(0, 255)));
				added++;
			end else if (pick < 92) begin
				k = $urandom_range(1, 10);
				add_readies(k);
				added += k;
			end else if (pick < 96) begin
				pending_items.push_back(rand_item(OP_UNUSED));
				added++;
			end else begin
				add_start(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
				added++;
			end
		end
	endtask

	// fill the buffer to the last byte, then drain it
	task automatic fill_to_brim();
		int room;
		int len;
		room = FIFO_DEPTH - tx_fill;
		if (in_frame) begin
			room -= int'(pay_left) + 2;
			repeat (pay_left) add_payload(8'($urandom_range(0, 255)));
		end
		while (room > 250) begin
			len = (room - 106 > 255) ? 255 : room - 106;
			add_frame(len);
			room -= len + FRAME_OVERHEAD;
		end
		add_start(8'd255, 16'($urandom_range(0, 65535)));
		if (room >= FRAME_OVERHEAD) begin
			add_start(8'(room - 5), 16'($urandom_range(0, 65535)));
			add_frame(room - FRAME_OVERHEAD);
		end
		add_start(8'd0, 16'($urandom_range(0, 65535)));
		add_payload(8'($urandom_range(0, 255)));
		add_readies(FIFO_DEPTH + 1);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HEADER)
			hdr_reg = val;
		else
			ftr_reg = val;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (16) @(posedge clk);
	endtask

	task automatic report_fault(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				predict_item(in_data);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (pending_items.size() != 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
					if ($urandom_range(0, 63) == 0)
						drv_burst = !drv_burst;
					send_gap = draw_wait(drv_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_fault($sformatf({"result %0d: none expected,",
						" got status %0d valid %0d byte %02h sending %0d"},
						result_count, out_data.status, out_data.line_valid,
						out_data.line_byte, out_data.sending));
				end else begin
					want = expected_results.pop_front();
					if (out_data.status !== want.status ||
							out_data.line_valid !== want.line_valid ||
							out_data.line_byte !== want.line_byte ||
							out_data.sending !== want.sending)
						report_fault($sformatf({"result %0d: expected status %0d",
							" valid %0d byte %02h sending %0d,",
							" got status %0d valid %0d byte %02h sending %0d"},
							result_count,
							want.status, want.line_valid, want.line_byte, want.sending,
							out_data.status, out_data.line_valid, out_data.line_byte,
							out_data.sending));
				end
				result_count++;
				if ($urandom_range(0, 63) == 0)
					mon_burst = !mon_burst;
				recv_gap = draw_wait(mon_burst);
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				out_ready <= 1'b0;
				recv_gap--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off while the sender keeps offering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		add_readies(1);
		add_payload(8'h5A);
		pending_items.push_back(rand_item(OP_UNUSED));
		add_start(8'd0, 16'hFFFF);
		add_start(8'd2, 16'h0000);
		add_start(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
		add_payload(8'hFF);
		add_payload(8'h00);
		add_readies(15);
		wait_idle();

		write_reg(REG_HEADER, 8'h00);
		write_reg(REG_FOOTER, 8'hFF);
		queue_random_traffic(200);
		wait_idle();

		write_reg(REG_HEADER, 8'hFF);
		write_reg(REG_FOOTER, 8'h00);
		@(posedge clk);
		hold_arm <= 1'b1;
		fill_to_brim();
		wait_idle();

		repeat (2) begin
			write_reg(REG_HEADER, 8'($urandom_range(0, 255)));
			write_reg(REG_FOOTER, 8'($urandom_range(0, 255)));
			queue_random_traffic(120);
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("checksummed_packet_framer: match");
		else
			$display("checksummed_packet_framer: mismatch");
		$finish;
	end

	initial begin
		#4000000;
		$display("checksummed_packet_framer: mismatch");
		$finish;
	end
endmodule

[filelist.f]
rtl/cpf_pkg.sv
rtl/cpf_ram.sv
rtl/checksummed_packet_framer.sv
test/tb.sv
